### hdl/hse_pkg.sv
// package with shared types and constants for the hot-plug slot enumerator
package hse_pkg;

    localparam logic [6:0]  SLOT_TARGET          = 7'h10;
    localparam logic [7:0]  PROTOCOL_VERSION     = 8'd1;
    localparam logic [6:0]  UNCONFIGURED_ADDRESS = 7'd8;
    localparam logic [15:0] TYPE_ID_ECHO         = 16'd1;
    localparam logic [15:0] TYPE_ID_SENSOR       = 16'd2;
    localparam logic [4:0]  IDENTITY_LEN         = 5'd5;

    typedef enum logic [4:0] {
        PH_EMPTY, PH_DEB_PRESENT, PH_DEB_ABSENT, PH_BOOT, PH_WAIT_LOCK, PH_SEL,
        PH_PROBE, PH_SETADDR, PH_VERIFY, PH_IDENT, PH_ONLINE, PH_UNSUP, PH_FAULT,
        PH_R_WAIT_LOCK, PH_R_SEL, PH_R_PROBE, PH_R_ASSIGNED
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_LOCK   = 2'd1,
        ACT_RESULT = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [2:0] PUB_EMPTY    = 3'd0;
    localparam logic [2:0] PUB_DEBOUNCE = 3'd1;
    localparam logic [2:0] PUB_ENUM     = 3'd2;
    localparam logic [2:0] PUB_ONLINE   = 3'd3;
    localparam logic [2:0] PUB_UNSUP    = 3'd4;
    localparam logic [2:0] PUB_FAULT    = 3'd5;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_NACK     = 3'd2;
    localparam logic [2:0] ST_BADFRAME = 3'd3;
    localparam logic [2:0] ST_OTHER    = 3'd4;

    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_PING_UNCFG = 3'd1;
    localparam logic [2:0] OP_SET_ADDR   = 3'd2;
    localparam logic [2:0] OP_PING_ASGN  = 3'd3;
    localparam logic [2:0] OP_GET_ID     = 3'd4;
    localparam logic [2:0] OP_HEALTH     = 3'd5;

    localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [2:0] REG_BOOT      = 3'd1;
    localparam logic [2:0] REG_SETTLE    = 3'd2;
    localparam logic [2:0] REG_FAULT     = 3'd3;
    localparam logic [2:0] REG_HEALTH    = 3'd4;
    localparam logic [2:0] REG_GAP       = 3'd5;
    localparam logic [2:0] REG_HLIMIT    = 3'd6;
    localparam logic [2:0] REG_RETRIES   = 3'd7;

    typedef struct packed {
        logic [15:0] presence_debounce_ms;
        logic [15:0] boot_wait_ms;
        logic [15:0] select_settle_ms;
        logic [15:0] fault_retry_ms;
        logic [15:0] health_ping_ms;
        logic [15:0] retry_gap_ms;
        logic [7:0]  health_fail_limit;
        logic [7:0]  command_retries;
    } cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte4;
        logic [7:0] payload_byte3;
        logic [7:0] payload_byte2;
        logic [7:0] payload_byte1;
        logic [7:0] payload_byte0;
        logic [4:0] payload_length;
        logic [2:0] result_status;
        logic       lock_granted;
        logic       sense_level;
        logic [1:0] action;
    } item_t;

    typedef struct packed {
        logic [31:0] identity_count;
        logic [15:0] module_firmware_version;
        logic [7:0]  module_protocol_version;
        logic [15:0] module_type;
        logic [6:0]  committed_address;
        logic [6:0]  assigned_address;
        logic [2:0]  fault_code;
        logic        select_driven_low;
        logic [6:0]  i2c_target;
        logic [2:0]  i2c_operation;
        logic        wants_lock;
        logic [2:0]  public_state;
    } result_t;

    function automatic logic [2:0] public_of(input phase_t p);
        unique case (p)
            PH_EMPTY:       return PUB_EMPTY;
            PH_DEB_PRESENT: return PUB_DEBOUNCE;
            PH_ONLINE:      return PUB_ONLINE;
            PH_UNSUP:       return PUB_UNSUP;
            PH_FAULT:       return PUB_FAULT;
            default:        return PUB_ENUM;
        endcase
    endfunction

    function automatic logic lock_phase(input phase_t p);
        return (p >= PH_WAIT_LOCK && p <= PH_IDENT) || (p >= PH_R_WAIT_LOCK);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

### hdl/hse_cfg_regs.sv
// configuration register file for the hot-plug slot enumerator
module hse_cfg_regs
    import hse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.presence_debounce_ms <= 16'd50;
            cfg_reg.boot_wait_ms         <= 16'd100;
            cfg_reg.select_settle_ms     <= 16'd5;
            cfg_reg.fault_retry_ms       <= 16'd1000;
            cfg_reg.health_ping_ms       <= 16'd1000;
            cfg_reg.retry_gap_ms         <= 16'd20;
            cfg_reg.health_fail_limit    <= 8'd3;
            cfg_reg.command_retries      <= 8'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: cfg_reg.presence_debounce_ms <= cfg_data;
                REG_BOOT:     cfg_reg.boot_wait_ms         <= cfg_data;
                REG_SETTLE:   cfg_reg.select_settle_ms     <= cfg_data;
                REG_FAULT:    cfg_reg.fault_retry_ms       <= cfg_data;
                REG_HEALTH:   cfg_reg.health_ping_ms       <= cfg_data;
                REG_GAP:      cfg_reg.retry_gap_ms         <= cfg_data;
                REG_HLIMIT:   cfg_reg.health_fail_limit    <= cfg_data[7:0];
                REG_RETRIES:  cfg_reg.command_retries      <= cfg_data[7:0];
                default:      cfg_reg.command_retries      <= cfg_reg.command_retries;
            endcase
        end
    end
endmodule

### hdl/hse_slot_fsm.sv
// slot state update and result formation for one item
module hse_slot_fsm
    import hse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);
    phase_t      phase_reg, phase_next, pbr_reg, pbr_next;
    logic [2:0]  prior_reg, prior_next;
    logic        lock_reg, lock_next, retry_reg, retry_next, sel_reg, sel_next;
    logic [7:0]  att_reg, att_next, hfc_reg, hfc_next;
    logic [6:0]  lat_reg, lat_next, com_reg, com_next;
    logic [15:0] type_reg, type_next, fw_reg, fw_next;
    logic [7:0]  ver_reg, ver_next;
    logic [31:0] epoch_reg, epoch_next;
    logic [2:0]  fault_reg, fault_next;
    logic [15:0] pe_reg, pe_next, re_reg, re_next, he_reg, he_next;

    logic        present;
    logic [2:0]  st;
    logic [7:0]  att_inc, hfc_inc;
    logic [15:0] id_type;
    logic [2:0]  op;
    logic [6:0]  tgt;
    logic        stepph;

    always_comb
    begin
        phase_next = phase_reg; pbr_next = pbr_reg; prior_next = prior_reg;
        lock_next = lock_reg; retry_next = retry_reg; sel_next = sel_reg;
        att_next = att_reg; hfc_next = hfc_reg; lat_next = lat_reg; com_next = com_reg;
        type_next = type_reg; fw_next = fw_reg; ver_next = ver_reg;
        epoch_next = epoch_reg; fault_next = fault_reg;
        pe_next = pe_reg; re_next = re_reg; he_next = he_reg;
        present = !item.sense_level;
        st      = (item.result_status > ST_OTHER) ? ST_OTHER : item.result_status;
        att_inc = att_reg + 8'd1;
        hfc_inc = hfc_reg + 8'd1;
        id_type = {item.payload_byte0, item.payload_byte1};

        unique case (action_t'(item.action))
            ACT_TICK:
            begin
                pe_next = sat_inc(pe_reg);
                re_next = sat_inc(re_reg);
                he_next = sat_inc(he_reg);
                if (phase_reg == PH_EMPTY)
                begin
                    if (present)
                    begin
                        phase_next = PH_DEB_PRESENT; pe_next = '0;
                    end
                end
                else if (phase_reg == PH_DEB_PRESENT || phase_reg == PH_DEB_ABSENT)
                begin
                    if ((phase_reg == PH_DEB_PRESENT) != present)
                    begin
                        if (present)
                            phase_next = pbr_reg;
                        else
                        begin
                            phase_next = PH_EMPTY; pbr_next = PH_EMPTY; prior_next = PUB_EMPTY;
                            sel_next = 1'b0; lock_next = 1'b0; retry_next = 1'b0;
                            att_next = '0; hfc_next = '0; lat_next = '0; com_next = '0;
                            type_next = '0; ver_next = '0; fw_next = '0; fault_next = ST_NONE;
                        end
                    end
                    else if (pe_next >= cfg.presence_debounce_ms)
                    begin
                        if (present)
                        begin
                            phase_next = PH_BOOT; pe_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_EMPTY; pbr_next = PH_EMPTY; prior_next = PUB_EMPTY;
                            sel_next = 1'b0; lock_next = 1'b0; retry_next = 1'b0;
                            att_next = '0; hfc_next = '0; lat_next = '0; com_next = '0;
                            type_next = '0; ver_next = '0; fw_next = '0; fault_next = ST_NONE;
                        end
                    end
                end
                else if (!present)
                begin
                    pbr_next = phase_reg; phase_next = PH_DEB_ABSENT; pe_next = '0;
                end
                else
                begin
                    priority case (phase_reg)
                        PH_BOOT:
                            if (pe_next >= cfg.boot_wait_ms)
                                phase_next = PH_WAIT_LOCK;
                        PH_SEL, PH_R_SEL:
                            if (pe_next >= cfg.select_settle_ms)
                            begin
                                phase_next = (phase_reg == PH_SEL) ? PH_PROBE : PH_R_PROBE;
                                att_next = '0; retry_next = 1'b0; pe_next = '0;
                            end
                        PH_FAULT:
                            if (pe_next >= cfg.fault_retry_ms)
                                phase_next = (com_reg != '0) ? PH_R_WAIT_LOCK : PH_WAIT_LOCK;
                        default:
                            phase_next = phase_reg;
                    endcase
                end
            end
            ACT_LOCK:
            begin
                lock_next = item.lock_granted;
                if (item.lock_granted && (phase_reg == PH_WAIT_LOCK
                                          || phase_reg == PH_R_WAIT_LOCK))
                begin
                    sel_next = 1'b1; pe_next = '0;
                    phase_next = (phase_reg == PH_WAIT_LOCK) ? PH_SEL : PH_R_SEL;
                end
            end
            ACT_RESULT:
            begin
                if (phase_reg == PH_ONLINE || phase_reg == PH_UNSUP)
                begin
                    he_next = '0;
                    if (st == ST_NONE)
                        hfc_next = '0;
                    else if (st != ST_BUSY)
                    begin
                        hfc_next = hfc_inc; fault_next = st;
                        if (hfc_inc >= cfg.health_fail_limit)
                        begin
                            hfc_next = '0; prior_next = public_of(phase_reg);
                            phase_next = PH_R_WAIT_LOCK;
                        end
                    end
                end
                else if (phase_reg == PH_R_PROBE && st == ST_NONE)
                begin
                    type_next = '0; ver_next = '0; fw_next = '0; lat_next = '0;
                    prior_next = PUB_EMPTY;
                    phase_next = PH_SETADDR; att_next = '0; retry_next = 1'b0; pe_next = '0;
                end
                else if (phase_reg == PH_R_PROBE && st == ST_NACK)
                begin
                    phase_next = PH_R_ASSIGNED; att_next = '0; retry_next = 1'b0; pe_next = '0;
                end
                else if ((phase_reg == PH_R_PROBE || phase_reg == PH_R_ASSIGNED
                          || phase_reg == PH_PROBE || phase_reg == PH_SETADDR
                          || phase_reg == PH_VERIFY || phase_reg == PH_IDENT)
                         && (st != ST_NONE || (phase_reg == PH_IDENT
                                               && item.payload_length != IDENTITY_LEN)))
                begin
                    fault_next = (st != ST_NONE) ? st : ST_BADFRAME;
                    if (att_inc >= cfg.command_retries)
                    begin
                        phase_next = PH_FAULT; pe_next = '0; retry_next = 1'b0;
                        att_next = '0; sel_next = 1'b0;
                    end
                    else
                    begin
                        att_next = att_inc; retry_next = 1'b1; re_next = '0;
                    end
                end
                else
                begin
                    priority case (phase_reg)
                        PH_R_ASSIGNED:
                        begin
                            sel_next = 1'b0;
                            if (type_reg == '0)
                            begin
                                if (lat_reg == '0)
                                    lat_next = com_reg;
                                phase_next = PH_IDENT; att_next = '0;
                                retry_next = 1'b0; pe_next = '0;
                            end
                            else
                            begin
                                he_next = '0; hfc_next = '0;
                                phase_next = (prior_reg == PUB_UNSUP) ? PH_UNSUP : PH_ONLINE;
                            end
                        end
                        PH_PROBE, PH_SETADDR, PH_VERIFY:
                        begin
                            att_next = '0; retry_next = 1'b0; pe_next = '0;
                            if (phase_reg == PH_PROBE)
                                phase_next = PH_SETADDR;
                            else if (phase_reg == PH_SETADDR)
                            begin
                                com_next = SLOT_TARGET; phase_next = PH_VERIFY;
                            end
                            else
                            begin
                                lat_next = com_reg; sel_next = 1'b0; phase_next = PH_IDENT;
                            end
                        end
                        PH_IDENT:
                        begin
                            type_next = id_type; ver_next = item.payload_byte2;
                            fw_next = {item.payload_byte3, item.payload_byte4};
                            epoch_next = epoch_reg + 32'd1;
                            he_next = '0; hfc_next = '0; fault_next = ST_NONE;
                            if (item.payload_byte2 == PROTOCOL_VERSION
                                && (id_type == TYPE_ID_ECHO || id_type == TYPE_ID_SENSOR))
                            begin
                                phase_next = PH_ONLINE; prior_next = PUB_ONLINE;
                            end
                            else
                            begin
                                phase_next = PH_UNSUP; prior_next = PUB_UNSUP;
                            end
                        end
                        default:
                            phase_next = phase_reg;
                    endcase
                end
            end
            default:
                phase_next = phase_reg;
        endcase
    end

    // proposed bus operation from the updated state
    always_comb
    begin
        op = OP_NONE;
        tgt = '0;
        stepph = (phase_next >= PH_PROBE && phase_next <= PH_IDENT)
                 || phase_next == PH_R_PROBE || phase_next == PH_R_ASSIGNED;
        if (phase_next == PH_ONLINE || phase_next == PH_UNSUP)
        begin
            if (lat_next != '0 && he_next >= cfg.health_ping_ms)
            begin
                op = OP_HEALTH; tgt = lat_next;
            end
        end
        else if (lock_next && stepph && (!retry_next || re_next >= cfg.retry_gap_ms))
        begin
            priority case (phase_next)
                PH_PROBE, PH_R_PROBE:
                begin
                    op = OP_PING_UNCFG; tgt = UNCONFIGURED_ADDRESS;
                end
                PH_SETADDR:
                begin
                    op = OP_SET_ADDR; tgt = UNCONFIGURED_ADDRESS;
                end
                PH_VERIFY, PH_R_ASSIGNED:
                begin
                    op = OP_PING_ASGN; tgt = com_next;
                end
                default:
                begin
                    op = OP_GET_ID; tgt = lat_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EMPTY; pbr_reg <= PH_EMPTY; prior_reg <= PUB_EMPTY;
            lock_reg <= 1'b0; retry_reg <= 1'b0; sel_reg <= 1'b0;
            att_reg <= '0; hfc_reg <= '0; lat_reg <= '0; com_reg <= '0;
            type_reg <= '0; fw_reg <= '0; ver_reg <= '0; epoch_reg <= '0;
            fault_reg <= ST_NONE; pe_reg <= '0; re_reg <= '0; he_reg <= '0;
            result <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; pbr_reg <= pbr_next; prior_reg <= prior_next;
            lock_reg <= lock_next; retry_reg <= retry_next; sel_reg <= sel_next;
            att_reg <= att_next; hfc_reg <= hfc_next; lat_reg <= lat_next;
            com_reg <= com_next; type_reg <= type_next; fw_reg <= fw_next;
            ver_reg <= ver_next; epoch_reg <= epoch_next; fault_reg <= fault_next;
            pe_reg <= pe_next; re_reg <= re_next; he_reg <= he_next;
            result.public_state <= public_of((phase_next == PH_DEB_ABSENT) ? pbr_next
                                                                           : phase_next);
            result.wants_lock <= (phase_next == PH_DEB_ABSENT)
                                 ? (lock_phase(pbr_next) || lock_next)
                                 : lock_phase(phase_next);
            result.i2c_operation <= op;
            result.i2c_target <= tgt;
            result.select_driven_low <= sel_next;
            result.fault_code <= fault_next;
            result.assigned_address <= lat_next;
            result.committed_address <= com_next;
            result.module_type <= type_next;
            result.module_protocol_version <= ver_next;
            result.module_firmware_version <= fw_next;
            result.identity_count <= epoch_next;
        end
    end
endmodule

### hdl/hotplug_slot_enumerator_core.sv
// top level of the hot-plug slot enumerator
//
// one slot's presence debounce, enumeration under a shared lock and health
// monitoring. s_axis carries one event item per transfer (tick, lock notify
// or bus result), m_axis one status item per event, cfg writes the eight
// timing and limit registers by index.
// an input item is registered, worked through the slot state logic and then
// held in the output stage; the status item is valid on m_axis once the
// state logic has stepped it into the output register. one item per
// cycle is sustained while the receiver is ready; the state logic steps
// once the output stage is free, so the output handshake sets the rate.
// if the receiver stalls, m_axis holds its item and s_axis keeps accepting
// while the input and output stages have room; ready drops once both hold
// items.
// reset clears all slot state to empty and loads the register defaults; the
// block is ready in the first cycle after reset.
module hotplug_slot_enumerator_core
    import hse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action, sense_level, lock_granted, result_status, payload_length,
    // payload_byte0 .. payload_byte4
    input  logic [55:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // public_state, wants_lock, i2c_operation, i2c_target, select_driven_low,
    // fault_code, assigned_address, committed_address, module_type,
    // module_protocol_version, module_firmware_version, identity_count
    output logic [103:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg, out_valid_reg;
    logic    step;
    result_t result;

    hse_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            item_reg <= item_t'(s_axis_tdata[51:0]);
    end

    hse_slot_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result;

`ifndef SYNTHESIS
    a_step_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> in_valid_reg)
        else $error("step without a held item");
    a_out_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_axis_tvalid)
        else $error("result missing after step");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
`endif
endmodule

### tb/hotplug_slot_enumerator_core_tb.sv
// testbench for the hot-plug slot enumerator: directed and random event items checked against a predictor
module hotplug_slot_enumerator_core_tb;
    import hse_pkg::*;

    class slot_scoreboard;
        cfg_t        cfg;
        phase_t      ph;
        phase_t      ph_saved;
        logic [2:0]  prev_pub;
        bit          lock_own;
        bit          retry_wait;
        bit          sel_low;
        logic [7:0]  attempts;
        logic [7:0]  hfails;
        logic [6:0]  addr_latched;
        logic [6:0]  addr_committed;
        logic [15:0] type_id;
        logic [7:0]  proto;
        logic [15:0] fw;
        logic [31:0] id_count;
        logic [2:0]  fault;
        logic [15:0] t_phase;
        logic [15:0] t_retry;
        logic [15:0] t_health;
        result_t     expq[$];
        int          errors;

        function new();
            cfg = '{16'd50, 16'd100, 16'd5, 16'd1000, 16'd1000, 16'd20, 8'd3, 8'd3};
            clear_slot();
            id_count = 0;
            t_phase  = 0;
            t_retry  = 0;
            t_health = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                REG_DEBOUNCE: cfg.presence_debounce_ms = d;
                REG_BOOT:     cfg.boot_wait_ms = d;
                REG_SETTLE:   cfg.select_settle_ms = d;
                REG_FAULT:    cfg.fault_retry_ms = d;
                REG_HEALTH:   cfg.health_ping_ms = d;
                REG_GAP:      cfg.retry_gap_ms = d;
                REG_HLIMIT:   cfg.health_fail_limit = d[7:0];
                default:      cfg.command_retries = d[7:0];
            endcase
        endfunction

        function logic [2:0] pub_of(phase_t p);
            case (p)
                PH_EMPTY:       return PUB_EMPTY;
                PH_DEB_PRESENT: return PUB_DEBOUNCE;
                PH_ONLINE:      return PUB_ONLINE;
                PH_UNSUP:       return PUB_UNSUP;
                PH_FAULT:       return PUB_FAULT;
                default:        return PUB_ENUM;
            endcase
        endfunction

        function logic [2:0] pub_now();
            return pub_of(ph == PH_DEB_ABSENT ? ph_saved : ph);
        endfunction

        function bit needs_lock(phase_t p);
            return (p >= PH_WAIT_LOCK && p <= PH_IDENT) ||
                   (p >= PH_R_WAIT_LOCK && p <= PH_R_ASSIGNED);
        endfunction

        function bit bus_step(phase_t p);
            return (p >= PH_PROBE && p <= PH_IDENT) || p == PH_R_PROBE || p == PH_R_ASSIGNED;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void clear_slot();
            sel_low        = 0;
            ph             = PH_EMPTY;
            ph_saved       = PH_EMPTY;
            prev_pub       = PUB_EMPTY;
            lock_own       = 0;
            retry_wait     = 0;
            attempts       = 0;
            hfails         = 0;
            addr_latched   = 0;
            addr_committed = 0;
            type_id        = 0;
            proto          = 0;
            fw             = 0;
            fault          = ST_NONE;
        endfunction

        function void begin_step(phase_t p);
            ph         = p;
            attempts   = 0;
            retry_wait = 0;
            t_phase    = 0;
        endfunction

        function void step_failed(logic [2:0] st);
            fault    = st;
            attempts = attempts + 8'd1;
            if (attempts >= cfg.command_retries)
            begin
                ph         = PH_FAULT;
                t_phase    = 0;
                retry_wait = 0;
                attempts   = 0;
                sel_low    = 0;
            end
            else
            begin
                retry_wait = 1;
                t_retry    = 0;
            end
        endfunction

        function void take_id(item_t it);
            if (it.payload_length != IDENTITY_LEN)
            begin
                step_failed(ST_BADFRAME);
                return;
            end
            type_id  = {it.payload_byte0, it.payload_byte1};
            proto    = it.payload_byte2;
            fw       = {it.payload_byte3, it.payload_byte4};
            id_count = id_count + 32'd1;
            t_health = 0;
            hfails   = 0;
            fault    = ST_NONE;
            if (proto == PROTOCOL_VERSION && (type_id == TYPE_ID_ECHO || type_id == TYPE_ID_SENSOR))
            begin
                ph       = PH_ONLINE;
                prev_pub = PUB_ONLINE;
            end
            else
            begin
                ph       = PH_UNSUP;
                prev_pub = PUB_UNSUP;
            end
        endfunction

        function void tick(bit present);
            t_phase  = bump(t_phase);
            t_retry  = bump(t_retry);
            t_health = bump(t_health);
            if (ph == PH_EMPTY)
            begin
                if (present)
                begin
                    ph      = PH_DEB_PRESENT;
                    t_phase = 0;
                end
            end
            else if (ph == PH_DEB_PRESENT)
            begin
                if (!present)
                    clear_slot();
                else if (t_phase >= cfg.presence_debounce_ms)
                begin
                    ph      = PH_BOOT;
                    t_phase = 0;
                end
            end
            else if (ph == PH_DEB_ABSENT)
            begin
                if (present)
                    ph = ph_saved;
                else if (t_phase >= cfg.presence_debounce_ms)
                    clear_slot();
            end
            else if (!present)
            begin
                ph_saved = ph;
                ph       = PH_DEB_ABSENT;
                t_phase  = 0;
            end
            else if (ph == PH_BOOT)
            begin
                if (t_phase >= cfg.boot_wait_ms)
                    ph = PH_WAIT_LOCK;
            end
            else if (ph == PH_SEL)
            begin
                if (t_phase >= cfg.select_settle_ms)
                    begin_step(PH_PROBE);
            end
            else if (ph == PH_R_SEL)
            begin
                if (t_phase >= cfg.select_settle_ms)
                    begin_step(PH_R_PROBE);
            end
            else if (ph == PH_FAULT)
            begin
                if (t_phase >= cfg.fault_retry_ms)
                    ph = (addr_committed != 0) ? PH_R_WAIT_LOCK : PH_WAIT_LOCK;
            end
        endfunction

        function void lock_notify(bit held);
            lock_own = held;
            if (held && ph == PH_WAIT_LOCK)
            begin
                sel_low = 1;
                ph      = PH_SEL;
                t_phase = 0;
            end
            else if (held && ph == PH_R_WAIT_LOCK)
            begin
                sel_low = 1;
                ph      = PH_R_SEL;
                t_phase = 0;
            end
        endfunction

        function void bus_result(item_t it);
            logic [2:0] st;
            st = (it.result_status > ST_OTHER) ? ST_OTHER : it.result_status;
            if (ph == PH_ONLINE || ph == PH_UNSUP)
            begin
                t_health = 0;
                if (st == ST_NONE)
                    hfails = 0;
                else if (st != ST_BUSY)
                begin
                    hfails = hfails + 8'd1;
                    fault  = st;
                    if (hfails >= cfg.health_fail_limit)
                    begin
                        hfails   = 0;
                        prev_pub = pub_now();
                        ph       = PH_R_WAIT_LOCK;
                    end
                end
                return;
            end
            case (ph)
                PH_R_PROBE:
                    if (st == ST_NONE)
                    begin
                        type_id      = 0;
                        proto        = 0;
                        fw           = 0;
                        addr_latched = 0;
                        prev_pub     = PUB_EMPTY;
                        begin_step(PH_SETADDR);
                    end
                    else if (st == ST_NACK)
                        begin_step(PH_R_ASSIGNED);
                    else
                        step_failed(st);
                PH_R_ASSIGNED:
                    if (st != ST_NONE)
                        step_failed(st);
                    else
                    begin
                        sel_low = 0;
                        if (type_id == 0)
                        begin
                            if (addr_latched == 0)
                                addr_latched = addr_committed;
                            begin_step(PH_IDENT);
                        end
                        else
                        begin
                            t_health = 0;
                            hfails   = 0;
                            ph       = (prev_pub == PUB_UNSUP) ? PH_UNSUP : PH_ONLINE;
                        end
                    end
                PH_PROBE:
                    if (st == ST_NONE)
                        begin_step(PH_SETADDR);
                    else
                        step_failed(st);
                PH_SETADDR:
                    if (st == ST_NONE)
                    begin
                        addr_committed = SLOT_TARGET;
                        begin_step(PH_VERIFY);
                    end
                    else
                        step_failed(st);
                PH_VERIFY:
                    if (st == ST_NONE)
                    begin
                        addr_latched = addr_committed;
                        sel_low      = 0;
                        begin_step(PH_IDENT);
                    end
                    else
                        step_failed(st);
                PH_IDENT:
                    if (st == ST_NONE)
                        take_id(it);
                    else
                        step_failed(st);
                default:
                    ;
            endcase
        endfunction

        function void note_item(item_t it);
            result_t r;
            r = '0;
            case (it.action)
                ACT_TICK:   tick(it.sense_level == 1'b0);
                ACT_LOCK:   lock_notify(it.lock_granted);
                ACT_RESULT: bus_result(it);
                default:    ;
            endcase
            r.i2c_operation = OP_NONE;
            r.i2c_target    = 0;
            if (ph == PH_ONLINE || ph == PH_UNSUP)
            begin
                if (addr_latched != 0 && t_health >= cfg.health_ping_ms)
                begin
                    r.i2c_operation = OP_HEALTH;
                    r.i2c_target    = addr_latched;
                end
            end
            else if (lock_own && bus_step(ph) && (!retry_wait || t_retry >= cfg.retry_gap_ms))
            begin
                case (ph)
                    PH_PROBE, PH_R_PROBE:
                    begin
                        r.i2c_operation = OP_PING_UNCFG;
                        r.i2c_target    = UNCONFIGURED_ADDRESS;
                    end
                    PH_SETADDR:
                    begin
                        r.i2c_operation = OP_SET_ADDR;
                        r.i2c_target    = UNCONFIGURED_ADDRESS;
                    end
                    PH_VERIFY, PH_R_ASSIGNED:
                    begin
                        r.i2c_operation = OP_PING_ASGN;
                        r.i2c_target    = addr_committed;
                    end
                    default:
                    begin
                        r.i2c_operation = OP_GET_ID;
                        r.i2c_target    = addr_latched;
                    end
                endcase
            end
            r.public_state = pub_now();
            r.wants_lock   = (ph == PH_DEB_ABSENT) ? (needs_lock(ph_saved) || lock_own)
                                                   : needs_lock(ph);
            r.select_driven_low       = sel_low;
            r.fault_code              = fault;
            r.assigned_address        = addr_latched;
            r.committed_address       = addr_committed;
            r.module_type             = type_id;
            r.module_protocol_version = proto;
            r.module_firmware_version = fw;
            r.identity_count          = id_count;
            expq.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $error("%s expected %0h actual %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_item(result_t a);
            result_t e;
            if (expq.size() == 0)
            begin
                $error("unexpected output item %0h", a);
                errors++;
                return;
            end
            e = expq.pop_front();
            cmp("public_state", e.public_state, a.public_state);
            cmp("wants_lock", e.wants_lock, a.wants_lock);
            cmp("i2c_operation", e.i2c_operation, a.i2c_operation);
            cmp("i2c_target", e.i2c_target, a.i2c_target);
            cmp("select_driven_low", e.select_driven_low, a.select_driven_low);
            cmp("fault_code", e.fault_code, a.fault_code);
            cmp("assigned_address", e.assigned_address, a.assigned_address);
            cmp("committed_address", e.committed_address, a.committed_address);
            cmp("module_type", e.module_type, a.module_type);
            cmp("module_protocol_version", e.module_protocol_version,
                a.module_protocol_version);
            cmp("module_firmware_version", e.module_firmware_version,
                a.module_firmware_version);
            cmp("identity_count", e.identity_count, a.identity_count);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    slot_scoreboard sb;
    bit             tx_idle;
    bit             rx_idle;
    bit             rx_hold;

    hotplug_slot_enumerator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 8) : 0;
            if (rx_hold)
            begin
                stall   = 400;
                rx_hold = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_item(m_axis_tdata);
        end
    end

    task automatic send(item_t it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expq.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(cfg_t c);
        logic [15:0] vals[8];
        vals = '{c.presence_debounce_ms, c.boot_wait_ms, c.select_settle_ms, c.fault_retry_ms,
                 c.health_ping_ms, c.retry_gap_ms,
                 {8'($urandom), c.health_fail_limit}, {8'($urandom), c.command_retries}};
        drain();
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(3'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t make_item(logic [1:0] act, bit sense, bit grant, logic [2:0] st,
                                        logic [4:0] len, logic [39:0] bytes);
        item_t it;
        it.action         = act;
        it.sense_level    = sense;
        it.lock_granted   = grant;
        it.result_status  = st;
        it.payload_length = len;
        {it.payload_byte0, it.payload_byte1, it.payload_byte2, it.payload_byte3,
         it.payload_byte4} = bytes;
        return it;
    endfunction

    function automatic item_t rand_event();
        int          pick;
        logic [39:0] bytes;
        pick  = $urandom_range(0, 99);
        bytes = {$urandom(), 8'($urandom())};
        if ($urandom_range(0, 3) != 0)
        begin
            bytes[39:24] = 16'($urandom_range(1, 2));
            bytes[23:16] = PROTOCOL_VERSION;
        end
        if (pick < 55)
            return make_item(ACT_TICK, $urandom_range(0, 9) == 0, 1'($urandom),
                             3'($urandom), 5'($urandom), bytes);
        if (pick < 70)
            return make_item(ACT_LOCK, 1'($urandom), $urandom_range(0, 6) != 0,
                             3'($urandom), 5'($urandom), bytes);
        if (pick < 98)
            return make_item(ACT_RESULT, 1'($urandom), 1'($urandom),
                             ($urandom_range(0, 9) < 6) ? ST_NONE : 3'($urandom_range(1, 7)),
                             ($urandom_range(0, 4) != 0) ? IDENTITY_LEN : 5'($urandom),
                             bytes);
        return make_item(ACT_NONE, 1'($urandom), 1'($urandom), 3'($urandom), 5'($urandom),
                         bytes);
    endfunction

    task automatic random_run(int n, bit pause_mid, bit hold_mid);
        for (int i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
                drain();
            if (hold_mid && i == n / 3)
                rx_hold = 1;
            if ($urandom_range(0, 99) < 3)
                repeat ($urandom_range(1, 6))
                    send(make_item(ACT_TICK, 1'b1, 0, 0, 0, 0));
            send(rand_event());
        end
    endtask

    initial
    begin
        cfg_t c;
        sb            = new();
        tx_idle       = 1;
        rx_idle       = 1;
        rx_hold       = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_item(ACT_NONE, 1, 1, 7, 31, '1));
        send(make_item(ACT_LOCK, 0, 0, 0, 0, 0));
        send(make_item(ACT_LOCK, 0, 1, 0, 0, 0));
        send(make_item(ACT_RESULT, 0, 0, 5, 5, 0));
        send(make_item(ACT_RESULT, 0, 0, 7, 0, '1));
        send(make_item(ACT_TICK, 1, 0, 0, 0, 0));
        send(make_item(ACT_TICK, 0, 0, 0, 0, 0));

        // all limits zero: first failure faults, first health failure recovers
        set_config('0);
        repeat (3) send(make_item(ACT_TICK, 1, 0, 0, 0, 0));
        repeat (3) send(make_item(ACT_TICK, 0, 0, 0, 0, 0));
        send(make_item(ACT_LOCK, 0, 1, 0, 0, 0));
        send(make_item(ACT_TICK, 0, 0, 0, 0, 0));
        repeat (3) send(make_item(ACT_RESULT, 0, 0, ST_NONE, 5, 0));
        send(make_item(ACT_RESULT, 0, 0, ST_NONE, 4, 40'h0001010203));
        send(make_item(ACT_TICK, 0, 0, 0, 0, 0));
        send(make_item(ACT_LOCK, 0, 1, 0, 0, 0));
        send(make_item(ACT_TICK, 0, 0, 0, 0, 0));
        send(make_item(ACT_RESULT, 0, 0, ST_NACK, 0, 0));
        send(make_item(ACT_RESULT, 0, 0, ST_NONE, 0, 0));
        send(make_item(ACT_RESULT, 0, 0, ST_NONE, 5, 40'h000101ABCD));

        // online with a short ping interval: health ping comes due back to back
        c = '0;
        c.health_ping_ms = 16'd32;
        set_config(c);
        tx_idle = 0;
        rx_idle = 0;
        repeat (40) send(make_item(ACT_TICK, 0, 0, 0, 0, 0));
        tx_idle = 1;
        rx_idle = 1;
        send(make_item(ACT_RESULT, 0, 0, ST_OTHER, 5, 0));

        random_run(80, 1, 1);
        set_config('{16'd2, 16'd3, 16'd1, 16'd5, 16'd4, 16'd1, 8'd2, 8'd3});
        random_run(80, 0, 0);
        set_config('{16'd1, 16'd0, 16'd2, 16'd2, 16'd1, 16'd3, 8'd1, 8'd2});
        tx_idle = 0;
        rx_idle = 0;
        random_run(80, 0, 0);
        tx_idle = 1;
        rx_idle = 1;
        set_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     8'hFF, 8'hFF});
        random_run(40, 0, 0);
        set_config('{16'd0, 16'd1, 16'd0, 16'd1, 16'd2, 16'd0, 8'd4, 8'd1});
        random_run(80, 0, 0);
        set_config('0);
        random_run(60, 0, 0);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expq.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### hotplug_slot_enumerator_core.f
hdl/hse_pkg.sv
hdl/hse_cfg_regs.sv
hdl/hse_slot_fsm.sv
hdl/hotplug_slot_enumerator_core.sv
tb/hotplug_slot_enumerator_core_tb.sv
